>>> hw/rtl/citi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// citi_pkg
// Shared types, widths and the silicon sample table of the index interpolator.
// ----------------------------------------------------------------------------
package citi_pkg;

    localparam int WL_W              = 16;
    localparam int VAL_W             = 32;
    localparam int OUT_W             = 32;
    localparam int FRAC_BITS         = 29;
    localparam int INT_BITS          = OUT_W - FRAC_BITS;
    localparam int ROM_DEPTH         = 33;
    localparam int ROM_AW            = $clog2(ROM_DEPTH);
    localparam int TABLE_ENTRIES_DEF = 33;
    localparam int SCALE_W           = 24;
    localparam int D_W               = WL_W + 1;
    localparam int PROD_W            = VAL_W + WL_W;
    localparam int NUM_W             = PROD_W + 1;
    localparam int DEN_W             = D_W + SCALE_W;
    localparam int CNT_W             = $clog2(OUT_W);

    // values are stored in units of 1e-7
    localparam logic [SCALE_W-1:0] VALUE_SCALE = SCALE_W'(10000000);

    typedef struct packed {
        logic [WL_W-1:0]  wl;
        logic [VAL_W-1:0] re;
        logic [VAL_W-1:0] im;
    } sample_t;

    function automatic sample_t rom_sample(input logic [ROM_AW-1:0] idx);
        sample_t s;
        case (idx)
            6'd0:    s = '{16'd1240,  32'd3060000,  32'd13800000};
            6'd1:    s = '{16'd1305,  32'd3320000,  32'd15100000};
            6'd2:    s = '{16'd1378,  32'd3670000,  32'd16600000};
            6'd3:    s = '{16'd1459,  32'd4140000,  32'd18200000};
            6'd4:    s = '{16'd1550,  32'd4780000,  32'd20000000};
            6'd5:    s = '{16'd1653,  32'd5630000,  32'd22100000};
            6'd6:    s = '{16'd1771,  32'd6820000,  32'd24500000};
            6'd7:    s = '{16'd1907,  32'd8470000,  32'd27300000};
            6'd8:    s = '{16'd2066,  32'd11100000, 32'd30500000};
            6'd9:    s = '{16'd2254,  32'd13400000, 32'd33020000};
            6'd10:   s = '{16'd2480,  32'd15700000, 32'd35650000};
            6'd11:   s = '{16'd2755,  32'd24510000, 32'd50820000};
            6'd12:   s = '{16'd3100,  32'd50100000, 32'd36500000};
            6'd13:   s = '{16'd3306,  32'd51050000, 32'd31110000};
            6'd14:   s = '{16'd3542,  32'd56100000, 32'd30140000};
            6'd15:   s = '{16'd3815,  32'd63890000, 32'd8800000};
            6'd16:   s = '{16'd4133,  32'd52220000, 32'd2690000};
            6'd17:   s = '{16'd4275,  32'd49610000, 32'd2030000};
            6'd18:   s = '{16'd4428,  32'd47530000, 32'd1630000};
            6'd19:   s = '{16'd4592,  32'd45830000, 32'd1300000};
            6'd20:   s = '{16'd4769,  32'd44420000, 32'd900000};
            6'd21:   s = '{16'd4959,  32'd43200000, 32'd730000};
            6'd22:   s = '{16'd5166,  32'd42150000, 32'd600000};
            6'd23:   s = '{16'd5391,  32'd41230000, 32'd480000};
            6'd24:   s = '{16'd5636,  32'd40420000, 32'd320000};
            6'd25:   s = '{16'd5904,  32'd39690000, 32'd300000};
            6'd26:   s = '{16'd6199,  32'd39060000, 32'd220000};
            6'd27:   s = '{16'd6526,  32'd38470000, 32'd160000};
            6'd28:   s = '{16'd6888,  32'd37960000, 32'd130000};
            6'd29:   s = '{16'd7293,  32'd37520000, 32'd100000};
            6'd30:   s = '{16'd7749,  32'd37140000, 32'd80000};
            6'd31:   s = '{16'd8266,  32'd36730000, 32'd50000};
            6'd32:   s = '{16'd12400, 32'd35163000, 32'd15};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/citi_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// citi_rom
// Synchronous sample ROM, one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module citi_rom (
    input  wire logic                        clk,
    input  wire logic [citi_pkg::ROM_AW-1:0] rd_addr,
    output citi_pkg::sample_t                rd_data
);
    import citi_pkg::*;

    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= rom_sample(rd_addr);
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/citi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// citi_div
// Restoring divider, one quotient bit per cycle for two numerators that share
// one denominator. Quotient is floor(num * 2^FRAC_BITS / den), OUT_W bits.
// ----------------------------------------------------------------------------
module citi_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [citi_pkg::NUM_W-1:0] num_a,
    input  wire logic [citi_pkg::NUM_W-1:0] num_b,
    input  wire logic [citi_pkg::DEN_W-1:0] den,
    output logic                            done,
    output logic      [citi_pkg::OUT_W-1:0] quo_a,
    output logic      [citi_pkg::OUT_W-1:0] quo_b
);
    import citi_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_a_reg;
    logic [DEN_W-1:0]     rem_b_reg;
    logic [OUT_W-1:0]     feed_a_reg;
    logic [OUT_W-1:0]     feed_b_reg;
    logic [OUT_W-1:0]     quo_a_reg;
    logic [OUT_W-1:0]     quo_b_reg;
    logic [DEN_W:0]       trial_a;
    logic [DEN_W:0]       trial_b;
    logic                 take_a;
    logic                 take_b;

    assign trial_a = {rem_a_reg, feed_a_reg[OUT_W-1]};
    assign trial_b = {rem_b_reg, feed_b_reg[OUT_W-1]};
    assign take_a  = trial_a >= {1'b0, den_reg};
    assign take_b  = trial_b >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(OUT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The integer part never reaches den, so the top bits seed the remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg    <= den;
            rem_a_reg  <= DEN_W'(num_a >> INT_BITS);
            rem_b_reg  <= DEN_W'(num_b >> INT_BITS);
            feed_a_reg <= OUT_W'(num_a << FRAC_BITS);
            feed_b_reg <= OUT_W'(num_b << FRAC_BITS);
            quo_a_reg  <= '0;
            quo_b_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_a_reg  <= take_a ? DEN_W'(trial_a - {1'b0, den_reg}) : trial_a[DEN_W-1:0];
            rem_b_reg  <= take_b ? DEN_W'(trial_b - {1'b0, den_reg}) : trial_b[DEN_W-1:0];
            feed_a_reg <= feed_a_reg << 1;
            feed_b_reg <= feed_b_reg << 1;
            quo_a_reg  <= {quo_a_reg[OUT_W-2:0], take_a};
            quo_b_reg  <= {quo_b_reg[OUT_W-2:0], take_b};
        end
    end

    assign done  = done_reg;
    assign quo_a = quo_a_reg;
    assign quo_b = quo_b_reg;

endmodule
`default_nettype wire

>>> hw/rtl/complex_index_table_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_index_table_interpolator
// Silicon complex refractive index by linear interpolation in a sample ROM.
// ----------------------------------------------------------------------------
// One item in, one item out. The wavelength (units of 0.0001 um) is compared
// against the sample ROM one entry per cycle, starting at the lowest sample,
// until the first segment holding it is found; outside the table the end
// sample is returned with clamped set. The two ends of the segment are
// weighted by their distances, then a shared 32-step restoring divider
// produces both Q3.29 results, truncated toward zero. An item passes from
// accept to result through the ROM walk, the multiply and sum, the divider
// and the load of the output register; a stalled receiver adds its stall on
// top. One item is in flight at a time; in_ready is high when the block is
// idle, even while the last result still waits in the output register.
// ----------------------------------------------------------------------------
module complex_index_table_interpolator #(
    parameter int TABLE_ENTRIES = citi_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [citi_pkg::WL_W-1:0]  wavelength,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [citi_pkg::OUT_W-1:0] index_real,
    output logic      [citi_pkg::OUT_W-1:0] index_imag,
    output logic                            clamped
);
    import citi_pkg::*;

    // only the stored samples take part, however large the table setting
    localparam int USED = (TABLE_ENTRIES > ROM_DEPTH) ? ROM_DEPTH : TABLE_ENTRIES;
    localparam logic [ROM_AW-1:0] LAST_IDX = ROM_AW'(USED - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_WALK,
        S_MUL,
        S_SUM,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [WL_W-1:0]     w_reg;
    logic [ROM_AW-1:0]   idx_reg;
    sample_t             a_reg;
    sample_t             b_reg;
    logic [WL_W-1:0]     d1_reg;
    logic [WL_W-1:0]     d2_reg;
    logic                clamp_reg;
    logic [PROD_W-1:0]   p_are_reg;
    logic [PROD_W-1:0]   p_bre_reg;
    logic [PROD_W-1:0]   p_aim_reg;
    logic [PROD_W-1:0]   p_bim_reg;
    logic [DEN_W-1:0]    den_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    index_real_reg;
    logic [OUT_W-1:0]    index_imag_reg;
    logic                clamped_reg;

    logic [ROM_AW-1:0]   rom_addr;
    sample_t             rom_data;
    logic [D_W-1:0]      d_sum;
    logic [NUM_W-1:0]    num_re;
    logic [NUM_W-1:0]    num_im;
    logic                div_start;
    logic                div_done;
    logic [OUT_W-1:0]    quo_re;
    logic [OUT_W-1:0]    quo_im;

    citi_rom u_rom (
        .clk     (clk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    citi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_a (num_re),
        .num_b (num_im),
        .den   (den_reg),
        .done  (div_done),
        .quo_a (quo_re),
        .quo_b (quo_im)
    );

    // Address the entry needed next cycle: entry 0 on accept, then walk up.
    always_comb
    begin
        unique case (state_reg)
            S_FIRST: rom_addr = ROM_AW'(1);
            S_WALK:  rom_addr = idx_reg + ROM_AW'(1);
            default: rom_addr = '0;
        endcase
    end

    assign d_sum     = {1'b0, d1_reg} + {1'b0, d2_reg};
    assign num_re    = NUM_W'(p_are_reg) + NUM_W'(p_bre_reg);
    assign num_im    = NUM_W'(p_aim_reg) + NUM_W'(p_bim_reg);
    assign div_start = (state_reg == S_SUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the result once it is taken, unless a new one replaces it
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        w_reg     <= wavelength;
                        state_reg <= S_FIRST;
                    end
                end

                S_FIRST:
                begin
                    a_reg <= rom_data;
                    if (w_reg < rom_data.wl)
                    begin
                        // below the table: the end sample, weight one
                        b_reg     <= rom_data;
                        d1_reg    <= '0;
                        d2_reg    <= WL_W'(1);
                        clamp_reg <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        idx_reg   <= ROM_AW'(1);
                        state_reg <= S_WALK;
                    end
                end

                S_WALK:
                begin
                    if (w_reg <= rom_data.wl)
                    begin
                        // first segment holding the wavelength
                        b_reg     <= rom_data;
                        d1_reg    <= w_reg - a_reg.wl;
                        d2_reg    <= rom_data.wl - w_reg;
                        clamp_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        // above the table: the last used sample
                        a_reg     <= rom_data;
                        b_reg     <= rom_data;
                        d1_reg    <= '0;
                        d2_reg    <= WL_W'(1);
                        clamp_reg <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        a_reg   <= rom_data;
                        idx_reg <= idx_reg + ROM_AW'(1);
                    end
                end

                S_MUL:
                begin
                    p_are_reg <= PROD_W'(a_reg.re) * PROD_W'(d2_reg);
                    p_bre_reg <= PROD_W'(b_reg.re) * PROD_W'(d1_reg);
                    p_aim_reg <= PROD_W'(a_reg.im) * PROD_W'(d2_reg);
                    p_bim_reg <= PROD_W'(b_reg.im) * PROD_W'(d1_reg);
                    den_reg   <= DEN_W'(d_sum) * DEN_W'(VALUE_SCALE);
                    state_reg <= S_SUM;
                end

                S_SUM:
                begin
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        index_real_reg <= quo_re;
                        index_imag_reg <= quo_im;
                        clamped_reg    <= clamp_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign index_real = index_real_reg;
    assign index_imag = index_imag_reg;
    assign clamped    = clamped_reg;

`ifndef ASSERT_OFF
    a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_FIRST))
        else $error("accepted item did not start the table walk");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (idx_reg != '0 && idx_reg <= LAST_IDX))
        else $error("table walk index out of range");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (den_reg != '0))
        else $error("zero denominator handed to divider");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the silicon complex index table interpolator.
// ----------------------------------------------------------------------------
// Wavelength queries are queued up front: a directed set that hits both ends
// of the input range, the table edges, exact sample points and segment
// interiors, then random queries weighted toward the table. A bursty driver
// offers them over valid/ready. Each accepted query is run through a local
// piecewise-linear predictor, and the monitor compares every result against
// the oldest prediction. The receiver stalls on a changing pattern, and twice
// holds off for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import citi_pkg::*;

    localparam int SAMPLES      = 33;
    localparam int FRAC         = 29;
    localparam int TAIL_CYCLES  = 100;   // comfortably above the worst-case latency
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int RANDOM_ITEMS = 1530;

    // one expected result of the block
    typedef struct packed {
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
        logic             clamped;
    } index_t;

    // one pending query; a drain entry makes the driver wait for all results
    typedef struct packed {
        logic            drain;
        logic [WL_W-1:0] wl;
    } query_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,      // always ready
        RX_COIN,      // ready half the time
        RX_PERIODIC,  // ready one cycle in rx_period
        RX_SPARSE     // mostly ready, an occasional stall
    } rx_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic [WL_W-1:0]      wavelength = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [OUT_W-1:0]     index_real;
    logic [OUT_W-1:0]     index_imag;
    logic                 clamped;

    // silicon samples: wavelength in 0.0001 um, values in units of 1e-7
    logic [15:0] si_wl [SAMPLES] = '{
        16'd1240, 16'd1305, 16'd1378, 16'd1459, 16'd1550, 16'd1653, 16'd1771,
        16'd1907, 16'd2066, 16'd2254, 16'd2480, 16'd2755, 16'd3100, 16'd3306,
        16'd3542, 16'd3815, 16'd4133, 16'd4275, 16'd4428, 16'd4592, 16'd4769,
        16'd4959, 16'd5166, 16'd5391, 16'd5636, 16'd5904, 16'd6199, 16'd6526,
        16'd6888, 16'd7293, 16'd7749, 16'd8266, 16'd12400
    };
    logic [31:0] si_re [SAMPLES] = '{
        32'd3060000,  32'd3320000,  32'd3670000,  32'd4140000,  32'd4780000,
        32'd5630000,  32'd6820000,  32'd8470000,  32'd11100000, 32'd13400000,
        32'd15700000, 32'd24510000, 32'd50100000, 32'd51050000, 32'd56100000,
        32'd63890000, 32'd52220000, 32'd49610000, 32'd47530000, 32'd45830000,
        32'd44420000, 32'd43200000, 32'd42150000, 32'd41230000, 32'd40420000,
        32'd39690000, 32'd39060000, 32'd38470000, 32'd37960000, 32'd37520000,
        32'd37140000, 32'd36730000, 32'd35163000
    };
    logic [31:0] si_im [SAMPLES] = '{
        32'd13800000, 32'd15100000, 32'd16600000, 32'd18200000, 32'd20000000,
        32'd22100000, 32'd24500000, 32'd27300000, 32'd30500000, 32'd33020000,
        32'd35650000, 32'd50820000, 32'd36500000, 32'd31110000, 32'd30140000,
        32'd8800000,  32'd2690000,  32'd2030000,  32'd1630000,  32'd1300000,
        32'd900000,   32'd730000,   32'd600000,   32'd480000,   32'd320000,
        32'd300000,   32'd220000,   32'd160000,   32'd130000,   32'd100000,
        32'd80000,    32'd50000,    32'd15
    };

    query_t   pending_q [$];     // queries not yet offered
    index_t   index_due_q [$];   // predicted results, oldest first
    int       errors     = 0;
    int       gap_left   = 0;
    int       burst_left = 0;
    int       hold_left  = 0;
    int       holds_done = 0;
    int       served     = 0;
    int       rx_cycle   = 0;
    int       rx_period  = 2;
    rx_mode_t rx_mode    = RX_OPEN;

    complex_index_table_interpolator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .wavelength (wavelength),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .index_real (index_real),
        .index_imag (index_imag),
        .clamped    (clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // floor(num * 2^29 / den), kept to the 32-bit result width
    function automatic logic [OUT_W-1:0] to_q29(input logic [63:0] num,
                                                input logic [63:0] den);
        logic [127:0] wide;
        wide = {64'd0, num} << FRAC;
        wide = wide / {64'd0, den};
        return wide[OUT_W-1:0];
    endfunction

    // Predict the complex index for one wavelength.
    function automatic index_t silicon_index(input logic [WL_W-1:0] wl);
        index_t      r;
        logic [63:0] d1;
        logic [63:0] d2;
        logic [63:0] scale;
        logic        found;
        int          e;
        scale = 64'd10000000;
        found = 1'b0;
        if (wl < si_wl[0] || wl > si_wl[SAMPLES-1])
        begin
            // outside the table: return the nearer end sample as stored
            e = (wl < si_wl[0]) ? 0 : SAMPLES - 1;
            r.re      = to_q29(64'(si_re[e]), scale);
            r.im      = to_q29(64'(si_im[e]), scale);
            r.clamped = 1'b1;
        end
        else
        begin
            r.re      = to_q29(64'(si_re[0]), scale);
            r.im      = to_q29(64'(si_im[0]), scale);
            r.clamped = 1'b0;
            // the first segment whose closed interval holds wl wins, so a
            // point shared by two segments is taken from the lower one
            for (int i = 0; i + 1 < SAMPLES; i++)
            begin
                if (!found && wl >= si_wl[i] && wl <= si_wl[i+1])
                begin
                    found = 1'b1;
                    d1 = 64'(wl - si_wl[i]);
                    d2 = 64'(si_wl[i+1] - wl);
                    r.re = to_q29(64'(si_re[i]) * d2 + 64'(si_re[i+1]) * d1,
                                  (d1 + d2) * scale);
                    r.im = to_q29(64'(si_im[i]) * d2 + 64'(si_im[i+1]) * d1,
                                  (d1 + d2) * scale);
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        errors++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer queued queries in bursts separated by random gaps.
    // A drain entry stalls the sender until every predicted result is back.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        query_t head;
        logic   offer;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            wavelength <= '0;
            gap_left   = 0;
            burst_left = 0;
        end
        else
        begin
            // predict every query the block takes at this edge
            if (in_valid && in_ready)
                index_due_q.push_back(silicon_index(wavelength));

            // the slot is free when nothing is offered or the offer was taken
            if (!in_valid || in_ready)
            begin
                offer = 1'b0;
                if (gap_left != 0)
                    gap_left--;
                else if (pending_q.size() != 0)
                begin
                    head = pending_q[0];
                    if (head.drain)
                    begin
                        // hold off until the block has delivered everything
                        if (index_due_q.size() == 0)
                            pending_q.delete(0);
                    end
                    else
                    begin
                        pending_q.delete(0);
                        offer = 1'b1;
                        wavelength <= head.wl;
                        if (burst_left <= 1)
                        begin
                            // new burst: now and then a long one with no gaps
                            burst_left = ($urandom_range(0, 3) == 0) ?
                                         $urandom_range(40, 120) : $urandom_range(1, 12);
                            gap_left   = $urandom_range(1, 15);
                        end
                        else
                            burst_left--;
                    end
                end
                in_valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long hold-off: after a set number of results, keep the receiver closed
    // for HOLD_CYCLES so the block fills up and stops taking queries.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : hold_off
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
            served     <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                served <= served + 1;
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if ((holds_done == 0 && served >= 150) ||
                     (holds_done == 1 && served >= 900))
            begin
                hold_left  <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each delivered result against the oldest prediction and
    // drive out_ready from a stall pattern that is picked anew at random.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        index_t want;
        logic   take;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle  = 0;
            rx_mode   = RX_OPEN;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (index_due_q.size() == 0)
                    flag_mismatch($sformatf("result with nothing expected: re=%h im=%h clamped=%b",
                                            index_real, index_imag, clamped));
                else
                begin
                    want = index_due_q.pop_front();
                    if (index_real !== want.re)
                        flag_mismatch($sformatf("index_real %h, expected %h",
                                                index_real, want.re));
                    if (index_imag !== want.im)
                        flag_mismatch($sformatf("index_imag %h, expected %h",
                                                index_imag, want.im));
                    if (clamped !== want.clamped)
                        flag_mismatch($sformatf("clamped %b, expected %b",
                                                clamped, want.clamped));
                end
            end

            rx_cycle++;
            if (rx_cycle % 160 == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                rx_period = $urandom_range(2, 8);
            end
            case (rx_mode)
                RX_OPEN:     take = 1'b1;
                RX_COIN:     take = ($urandom_range(0, 1) == 1);
                RX_PERIODIC: take = (rx_cycle % rx_period == 0);
                default:     take = ($urandom_range(0, 7) != 0);
            endcase
            out_ready <= take && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [WL_W-1:0] wl;
        int              pick;
        int              idx;
        rst_n = 1'b0;

        // directed: range ends, table edges, sample points, segment interiors
        pending_q.push_back('{1'b0, 16'd0});
        pending_q.push_back('{1'b0, 16'hFFFF});
        pending_q.push_back('{1'b0, 16'd1239});     // just below the table
        pending_q.push_back('{1'b0, 16'd1240});     // first sample exactly
        pending_q.push_back('{1'b0, 16'd1241});
        pending_q.push_back('{1'b0, 16'd1272});     // inside the first segment
        pending_q.push_back('{1'b0, 16'd1305});     // point shared by two segments
        pending_q.push_back('{1'b0, 16'd2755});     // peak of the extinction curve
        pending_q.push_back('{1'b0, 16'd3000});
        pending_q.push_back('{1'b0, 16'd3815});     // peak of the real index
        pending_q.push_back('{1'b0, 16'd3816});
        pending_q.push_back('{1'b0, 16'd8265});
        pending_q.push_back('{1'b0, 16'd8266});
        pending_q.push_back('{1'b0, 16'd8267});     // widest segment
        pending_q.push_back('{1'b0, 16'd10333});
        pending_q.push_back('{1'b0, 16'd12399});
        pending_q.push_back('{1'b0, 16'd12400});    // last sample exactly
        pending_q.push_back('{1'b0, 16'd12401});    // just above the table
        pending_q.push_back('{1'b0, 16'h7FFF});
        pending_q.push_back('{1'b0, 16'h8000});
        pending_q.push_back('{1'b0, 16'h5555});
        pending_q.push_back('{1'b0, 16'hAAAA});

        // random: mostly inside the table, some off either end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 500 || n == 1100)
                pending_q.push_back('{1'b1, 16'd0});
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, SAMPLES - 2);
            if (pick < 30)
                wl = si_wl[$urandom_range(0, SAMPLES - 1)];
            else if (pick < 72)
                wl = WL_W'($urandom_range(si_wl[idx], si_wl[idx+1]));
            else if (pick < 82)
                wl = $urandom_range(0, 1) ? si_wl[idx+1] - 16'd1 : si_wl[idx] + 16'd1;
            else if (pick < 90)
                wl = WL_W'($urandom_range(0, 1239));
            else
                wl = WL_W'($urandom_range(0, 65535));
            pending_q.push_back('{1'b0, wl});
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every query to be taken, then for every result
        while (pending_q.size() != 0 || in_valid)
            @(posedge clk);
        while (index_due_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (index_due_q.size() != 0)
        begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    index_due_q.size()));
            index_due_q.delete();
        end

        if (errors == 0)
            $display("complex_index_table_interpolator verification clean");
        else
            $display("complex_index_table_interpolator verification failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("complex_index_table_interpolator verification failed");
        $finish;
    end

endmodule
